// ===== hdl/vrt_pkg.sv =====
`default_nettype none
package vrt_pkg;
    localparam int CHUNK_EDGE   = 16;
    localparam int WORLD_CHUNKS = 4;
    localparam int WORLD_HEIGHT = 64;
    localparam int CRD_W        = 6;
    localparam int ORG_W        = 22;
    localparam int DIR_W        = 16;
    localparam int FRAC_W       = 16;
    localparam int MAG_W        = 15;
    localparam int NUM_W        = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_we;
        logic wr_we;
        logic rd_en;
        logic cmp_load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic org_out;
        logic walk_out;
        logic all_inf;
        logic solid;
        logic clr_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/vrt_ram.sv =====
`default_nettype none
module vrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/vrt_datapath.sv =====
`default_nettype none
module vrt_datapath #(
    parameter int CHUNK_EDGE   = vrt_pkg::CHUNK_EDGE,
    parameter int WORLD_CHUNKS = vrt_pkg::WORLD_CHUNKS,
    parameter int WORLD_HEIGHT = vrt_pkg::WORLD_HEIGHT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire vrt_pkg::t_cmd              i_cmd,
    output vrt_pkg::t_sts                   o_sts,
    input  wire logic                       i_operation,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_z,
    input  wire logic                       i_voxel_solid,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_x,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_y,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_z,
    output logic [vrt_pkg::CRD_W-1:0]       o_pos_x,
    output logic [vrt_pkg::CRD_W-1:0]       o_pos_y,
    output logic [vrt_pkg::CRD_W-1:0]       o_pos_z
);
    localparam int WE    = CHUNK_EDGE * WORLD_CHUNKS;
    localparam int XW    = $clog2(WE);
    localparam int YW    = $clog2(WORLD_HEIGHT);
    localparam int PW    = 10;
    localparam int AW    = 2 * XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = vrt_pkg::NUM_W;
    localparam int MW    = vrt_pkg::MAG_W + 1;
    localparam int PRW   = NW + MW;
    localparam int OW    = vrt_pkg::ORG_W - vrt_pkg::FRAC_W;

    // held item
    logic            r_op, r_solid;
    logic [OW-1:0]   r_wx, r_wy, r_wz;
    // walk state, world coordinates, signed wide enough to step out
    logic signed [PW-1:0] r_px, r_py, r_pz;
    logic signed [PW-1:0] r_bx, r_bz;
    logic signed [1:0]    r_sx, r_sy, r_sz;
    logic [NW-1:0]   r_nx, r_ny, r_nz;
    logic [MW-1:0]   r_mx, r_my, r_mz;
    logic            r_org_out;
    // products, registered
    logic [PRW-1:0]  r_nx_my, r_ny_mx, r_nx_mz, r_nz_mx, r_ny_mz, r_nz_my;
    logic [AW-1:0]   r_clr;

    function automatic logic signed [1:0] f_sgn(input logic signed [vrt_pkg::DIR_W-1:0] d);
        return (d > 0) ? 2'sd1 : ((d < 0) ? -2'sd1 : 2'sd0);
    endfunction
    function automatic logic [MW-1:0] f_mag(input logic signed [vrt_pkg::DIR_W-1:0] d);
        logic [vrt_pkg::DIR_W:0] e;
        e = {d[vrt_pkg::DIR_W-1], d};
        if (d < 0) e = -e;
        return e[MW-1:0];
    endfunction
    function automatic logic [NW-1:0] f_num(input logic signed [vrt_pkg::DIR_W-1:0] d,
                                            input logic [vrt_pkg::FRAC_W-1:0] fr);
        logic [NW-1:0] n;
        n = '0;
        if (d > 0) n = NW'(32'd65536) - NW'(fr);
        else if (d < 0) n = NW'(fr);
        return n;
    endfunction
    // lowest voxel of the chunk holding a coordinate, by compare against chunk starts
    function automatic logic signed [PW-1:0] f_base(input logic [OW-1:0] o);
        logic signed [PW-1:0] b;
        b = '0;
        for (int c = 1; c < WORLD_CHUNKS; c++) begin
            if (32'(o) >= 32'(c * CHUNK_EDGE)) b = PW'(c * CHUNK_EDGE);
        end
        return b;
    endfunction

    logic [OW-1:0] ox, oy, oz;
    assign ox = i_origin_x[vrt_pkg::ORG_W-1 -: OW];
    assign oy = i_origin_y[vrt_pkg::ORG_W-1 -: OW];
    assign oz = i_origin_z[vrt_pkg::ORG_W-1 -: OW];

    // latch item and set up the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_solid   <= i_voxel_solid;
            r_wx      <= i_voxel_x;
            r_wy      <= i_voxel_y;
            r_wz      <= i_voxel_z;
            r_org_out <= (32'(ox) >= WE) || (32'(oy) >= WORLD_HEIGHT) || (32'(oz) >= WE);
            r_px      <= PW'(ox);
            r_py      <= PW'(oy);
            r_pz      <= PW'(oz);
            r_bx      <= f_base(ox);
            r_bz      <= f_base(oz);
            r_sx      <= f_sgn(i_dir_x);
            r_sy      <= f_sgn(i_dir_y);
            r_sz      <= f_sgn(i_dir_z);
            r_mx      <= f_mag(i_dir_x);
            r_my      <= f_mag(i_dir_y);
            r_mz      <= f_mag(i_dir_z);
            r_nx      <= f_num(i_dir_x, i_origin_x[vrt_pkg::FRAC_W-1:0]);
            r_ny      <= f_num(i_dir_y, i_origin_y[vrt_pkg::FRAC_W-1:0]);
            r_nz      <= f_num(i_dir_z, i_origin_z[vrt_pkg::FRAC_W-1:0]);
        end else if (i_cmd.step) begin
            logic lxy, lxz, lyz, ax, ay;
            lxy = (r_sx != 0) && ((r_sy == 0) || (r_nx_my < r_ny_mx));
            lxz = (r_sx != 0) && ((r_sz == 0) || (r_nx_mz < r_nz_mx));
            lyz = (r_sy != 0) && ((r_sz == 0) || (r_ny_mz < r_nz_my));
            ax  = lxy && lxz;
            ay  = !lxy && lyz;
            // advance one axis
            if (ax) begin
                r_px <= r_px + PW'(r_sx);
                r_nx <= r_nx + NW'(32'd65536);
            end else if (ay) begin
                r_py <= r_py + PW'(r_sy);
                r_ny <= r_ny + NW'(32'd65536);
            end else begin
                r_pz <= r_pz + PW'(r_sz);
                r_nz <= r_nz + NW'(32'd65536);
            end
        end
    end

    // cross products for the tMax compares
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_load) begin
            r_nx_my <= PRW'(r_nx) * PRW'(r_my);
            r_ny_mx <= PRW'(r_ny) * PRW'(r_mx);
            r_nx_mz <= PRW'(r_nx) * PRW'(r_mz);
            r_nz_mx <= PRW'(r_nz) * PRW'(r_mx);
            r_ny_mz <= PRW'(r_ny) * PRW'(r_mz);
            r_nz_my <= PRW'(r_nz) * PRW'(r_my);
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_we) r_clr <= r_clr + AW'(1);
    end

    logic [AW-1:0] waddr, raddr, wsel;
    logic          wr_ok, we, wd;
    assign wr_ok = (32'(r_wx) < WE) && (32'(r_wy) < WORLD_HEIGHT) && (32'(r_wz) < WE);
    assign wsel  = {XW'(r_wx), XW'(r_wz), YW'(r_wy)};
    assign raddr = {r_px[XW-1:0], r_pz[XW-1:0], r_py[YW-1:0]};
    assign we    = i_cmd.clr_we || (i_cmd.wr_we && wr_ok);
    assign waddr = i_cmd.clr_we ? r_clr : wsel;
    assign wd    = i_cmd.clr_we ? 1'b0 : r_solid;

    logic rd;
    vrt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign o_sts.is_write = (r_op == vrt_pkg::OP_WRITE);
    assign o_sts.org_out  = r_org_out;
    assign o_sts.walk_out = (r_px < r_bx) || (r_px >= r_bx + PW'(CHUNK_EDGE)) ||
                            (r_py < 0) || (r_py >= PW'(WORLD_HEIGHT)) ||
                            (r_pz < r_bz) || (r_pz >= r_bz + PW'(CHUNK_EDGE));
    assign o_sts.all_inf  = (r_sx == 0) && (r_sy == 0) && (r_sz == 0);
    assign o_sts.solid    = rd;
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_pos_x        = r_px[vrt_pkg::CRD_W-1:0];
    assign o_pos_y        = r_py[vrt_pkg::CRD_W-1:0];
    assign o_pos_z        = r_pz[vrt_pkg::CRD_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/vrt_ctrl.sv =====
`default_nettype none
module vrt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output vrt_pkg::t_cmd      o_cmd,
    input  wire vrt_pkg::t_sts i_sts,
    output logic               o_done,
    output logic               o_hit
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DECODE, S_READ, S_TEST} t_state;
    t_state r_state, n_state;
    logic   r_done, r_hit, n_done, n_hit;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_hit   = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_write) begin
                    o_cmd.wr_we = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.org_out || i_sts.walk_out) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.cmp_load = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_sts.solid) begin
                    n_done  = 1'b1;
                    n_hit   = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.all_inf) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_hit   <= n_hit;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_hit  = r_hit;
endmodule
`default_nettype wire

// ===== hdl/voxel_ray_traversal_unit.sv =====
`default_nettype none
// Voxel ray caster over a one-bit occupancy memory. After reset the block
// sweeps the memory to air, one voxel a cycle (64*64*64 voxels at default
// size), holding busy high. A write item gives no result. A cast item walks
// the chunk holding its origin: after the accepting cycle, each voxel visited
// passes address set-up, memory read and compare-and-step, and a last
// address set-up ends the walk when it leaves the chunk; a walk visits at
// most 2*CHUNK_EDGE+WORLD_HEIGHT-2 voxels. The result strobe o_done is high for
// one cycle and cannot be stalled; busy falls with it.
module voxel_ray_traversal_unit #(
    parameter int CHUNK_EDGE   = vrt_pkg::CHUNK_EDGE,
    parameter int WORLD_CHUNKS = vrt_pkg::WORLD_CHUNKS,
    parameter int WORLD_HEIGHT = vrt_pkg::WORLD_HEIGHT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_operation,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]  i_voxel_z,
    input  wire logic                       i_voxel_solid,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_x,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_y,
    input  wire logic [vrt_pkg::ORG_W-1:0]  i_origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0] i_dir_z,
    output logic                            o_done,
    output logic                            o_hit,
    output logic [vrt_pkg::CRD_W-1:0]       o_hit_x,
    output logic [vrt_pkg::CRD_W-1:0]       o_hit_y,
    output logic [vrt_pkg::CRD_W-1:0]       o_hit_z
);
    vrt_pkg::t_cmd cmd;
    vrt_pkg::t_sts sts;
    logic [vrt_pkg::CRD_W-1:0] px, py, pz;

    vrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts),
        .o_done  (o_done),
        .o_hit   (o_hit)
    );

    vrt_datapath #(
        .CHUNK_EDGE   (CHUNK_EDGE),
        .WORLD_CHUNKS (WORLD_CHUNKS),
        .WORLD_HEIGHT (WORLD_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_voxel_x     (i_voxel_x),
        .i_voxel_y     (i_voxel_y),
        .i_voxel_z     (i_voxel_z),
        .i_voxel_solid (i_voxel_solid),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .o_pos_x       (px),
        .o_pos_y       (py),
        .o_pos_z       (pz)
    );

    // zero coordinates on a miss
    assign o_hit_x = o_hit ? px : '0;
    assign o_hit_y = o_hit ? py : '0;
    assign o_hit_z = o_hit ? pz : '0;
endmodule
`default_nettype wire

// ===== hdl/vrt_checker.sv =====
`default_nettype none
module vrt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_hit,
    input wire logic [5:0] o_hit_x,
    input wire logic [5:0] o_hit_y,
    input wire logic [5:0] o_hit_z
);
    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept without busy");
    // results only come from a running item
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result while idle");
    // a strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    // miss reports zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_x == 6'd0 && o_hit_y == 6'd0 && o_hit_z == 6'd0))
        else $error("miss with coordinates");
endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_hit   (o_hit),
    .o_hit_x (o_hit_x),
    .o_hit_y (o_hit_y),
    .o_hit_z (o_hit_z)
);
`default_nettype wire

// ===== tb/sv/vrt_ray_checker.sv =====
`default_nettype none
module vrt_ray_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              i_operation,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_voxel_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_voxel_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_voxel_z,
    input  wire logic                              i_voxel_solid,
    input  wire logic [vrt_pkg::ORG_W-1:0]         i_origin_x,
    input  wire logic [vrt_pkg::ORG_W-1:0]         i_origin_y,
    input  wire logic [vrt_pkg::ORG_W-1:0]         i_origin_z,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  i_dir_x,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  i_dir_y,
    input  wire logic signed [vrt_pkg::DIR_W-1:0]  i_dir_z,
    input  wire logic                              i_done,
    input  wire logic                              i_hit,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_hit_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_hit_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]         i_hit_z,
    output int                                     o_errors,
    output int                                     o_pending,
    output int                                     o_casts,
    output int                                     o_hits
);
    localparam int CE   = vrt_pkg::CHUNK_EDGE;
    localparam int WH   = vrt_pkg::WORLD_HEIGHT;
    localparam int CW   = vrt_pkg::CRD_W;
    localparam int OW   = vrt_pkg::ORG_W;
    localparam int FW   = vrt_pkg::FRAC_W;
    localparam int DW   = vrt_pkg::DIR_W;
    localparam int EDGE = CE * vrt_pkg::WORLD_CHUNKS;

    typedef struct {
        logic          hit;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } t_ray_hit;

    bit       solid_map [EDGE][WH][EDGE];
    t_ray_hit hit_queue [$];

    // walk the chunk holding the origin, exact rational DDA
    function automatic t_ray_hit trace_ray(input logic [OW-1:0] org [3],
                                           input logic signed [DW-1:0] dir [3]);
        t_ray_hit r;
        int       pos [3];
        int       stp [3];
        bit       inf [3];
        longint   num [3];
        longint   mag [3];
        int       lim [3];
        int       base [3];
        int       k;
        bit       x_lt_y, x_lt_z, y_lt_z;
        r = '{hit: 1'b0, x: '0, y: '0, z: '0};
        // an origin outside the world misses
        if (int'(org[0][OW-1:FW]) >= EDGE || int'(org[1][OW-1:FW]) >= WH ||
            int'(org[2][OW-1:FW]) >= EDGE)
            return r;
        base[0] = (org[0][OW-1:FW] / CE) * CE;
        base[1] = 0;
        base[2] = (org[2][OW-1:FW] / CE) * CE;
        lim[0] = CE;
        lim[1] = WH;
        lim[2] = CE;
        for (k = 0; k < 3; k++) begin
            pos[k] = int'(org[k][OW-1:FW]) - base[k];
            if (dir[k] > 0) begin
                stp[k] = 1; inf[k] = 0; mag[k] = dir[k];
                num[k] = 65536 - longint'(org[k][FW-1:0]);
            end else if (dir[k] < 0) begin
                stp[k] = -1; inf[k] = 0; mag[k] = -longint'(dir[k]);
                num[k] = org[k][FW-1:0];
            end else begin
                stp[k] = 0; inf[k] = 1; mag[k] = 0; num[k] = 0;
            end
        end
        while (pos[0] >= 0 && pos[0] < lim[0] && pos[1] >= 0 && pos[1] < lim[1] &&
               pos[2] >= 0 && pos[2] < lim[2]) begin
            if (solid_map[pos[0] + base[0]][pos[1]][pos[2] + base[2]]) begin
                r.hit = 1'b1;
                r.x = CW'(pos[0] + base[0]);
                r.y = CW'(pos[1]);
                r.z = CW'(pos[2] + base[2]);
                return r;
            end
            if (inf[0] && inf[1] && inf[2]) break;
            x_lt_y = !inf[0] && (inf[1] || num[0] * mag[1] < num[1] * mag[0]);
            x_lt_z = !inf[0] && (inf[2] || num[0] * mag[2] < num[2] * mag[0]);
            y_lt_z = !inf[1] && (inf[2] || num[1] * mag[2] < num[2] * mag[1]);
            if (x_lt_y) k = x_lt_z ? 0 : 2;
            else k = y_lt_z ? 1 : 2;
            pos[k] += stp[k];
            num[k] += 65536;
        end
        return r;
    endfunction

    assign o_pending = hit_queue.size();

    initial begin
        o_errors = 0;
        o_casts  = 0;
        o_hits   = 0;
    end

    // compare the finished cast, then take in the newly accepted item
    always @(posedge i_clk) begin
        t_ray_hit                want;
        logic [OW-1:0]           org [3];
        logic signed [DW-1:0]    dir [3];
        if (i_rst_n) begin
            if (i_done) begin
                if (hit_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected cast result hit=%0d (%0d,%0d,%0d)",
                                 i_hit, i_hit_x, i_hit_y, i_hit_z);
                end else begin
                    want = hit_queue.pop_front();
                    if (want.hit !== i_hit || want.x !== i_hit_x || want.y !== i_hit_y ||
                        want.z !== i_hit_z) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"cast mismatch: want hit=%0d (%0d,%0d,%0d)",
                                      " got hit=%0d (%0d,%0d,%0d)"},
                                     want.hit, want.x, want.y, want.z,
                                     i_hit, i_hit_x, i_hit_y, i_hit_z);
                    end
                end
            end
            if (start && !busy) begin
                if (i_operation == vrt_pkg::OP_WRITE) begin
                    if (i_voxel_x < EDGE && i_voxel_y < WH && i_voxel_z < EDGE)
                        solid_map[i_voxel_x][i_voxel_y][i_voxel_z] = i_voxel_solid;
                end else begin
                    org = '{i_origin_x, i_origin_y, i_origin_z};
                    dir = '{i_dir_x, i_dir_y, i_dir_z};
                    want = trace_ray(org, dir);
                    o_casts++;
                    if (want.hit) o_hits++;
                    hit_queue.push_back(want);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_voxel_ray_traversal_unit.sv =====
`default_nettype none
module tb_voxel_ray_traversal_unit;
    localparam int CW = vrt_pkg::CRD_W;
    localparam int OW = vrt_pkg::ORG_W;
    localparam int DW = vrt_pkg::DIR_W;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_operation = vrt_pkg::OP_WRITE;
    logic [CW-1:0]            i_voxel_x = '0;
    logic [CW-1:0]            i_voxel_y = '0;
    logic [CW-1:0]            i_voxel_z = '0;
    logic                     i_voxel_solid = 1'b0;
    logic [OW-1:0]            i_origin_x = '0;
    logic [OW-1:0]            i_origin_y = '0;
    logic [OW-1:0]            i_origin_z = '0;
    logic signed [DW-1:0]     i_dir_x = '0;
    logic signed [DW-1:0]     i_dir_y = '0;
    logic signed [DW-1:0]     i_dir_z = '0;
    logic                     o_done;
    logic                     o_hit;
    logic [CW-1:0]            o_hit_x;
    logic [CW-1:0]            o_hit_y;
    logic [CW-1:0]            o_hit_z;
    int                       errors;
    int                       pending;
    int                       casts;
    int                       hits;
    bit                       calm;

    always #2 i_clk = ~i_clk;

    voxel_ray_traversal_unit i_dut (.*);

    vrt_ray_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_operation,
        .i_voxel_x, .i_voxel_y, .i_voxel_z, .i_voxel_solid,
        .i_origin_x, .i_origin_y, .i_origin_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_done(o_done), .i_hit(o_hit), .i_hit_x(o_hit_x), .i_hit_y(o_hit_y),
        .i_hit_z(o_hit_z),
        .o_errors(errors), .o_pending(pending), .o_casts(casts), .o_hits(hits)
    );

    // hold the item on the ports until accepted, then step to the next edge
    task automatic offer_item();
        start <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // idle a random number of cycles in about 37 of a hundred calls, unless calm
    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 37) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic put_voxel(input int x, input int y, input int z, input bit s);
        i_operation   <= vrt_pkg::OP_WRITE;
        i_voxel_x     <= CW'(x);
        i_voxel_y     <= CW'(y);
        i_voxel_z     <= CW'(z);
        i_voxel_solid <= s;
        i_origin_x    <= OW'($urandom);
        i_dir_x       <= DW'($urandom);
        offer_item();
    endtask

    task automatic cast_ray(input logic [OW-1:0] ox, input logic [OW-1:0] oy,
                            input logic [OW-1:0] oz, input logic signed [DW-1:0] dx,
                            input logic signed [DW-1:0] dy,
                            input logic signed [DW-1:0] dz);
        i_operation   <= vrt_pkg::OP_CAST;
        i_origin_x    <= ox;
        i_origin_y    <= oy;
        i_origin_z    <= oz;
        i_dir_x       <= dx;
        i_dir_y       <= dy;
        i_dir_z       <= dz;
        i_voxel_x     <= CW'($urandom);
        i_voxel_solid <= 1'($urandom);
        offer_item();
    endtask

    // direction component: mostly in the unit range, sometimes any 16 bits or zero
    function automatic logic signed [DW-1:0] pick_dir();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 25) return DW'($urandom);
        return DW'($urandom_range(32768) - 16384);
    endfunction

    // origin: mostly inside the dense corner, sometimes anywhere
    function automatic logic [OW-1:0] pick_org(input bit dense);
        if (dense) return {6'($urandom_range(15)), 16'($urandom)};
        return OW'($urandom);
    endfunction

    initial begin
        #(4 * 3_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int n;
        bit dense;
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: store corners, zero direction, boundaries, ties, extreme directions
        put_voxel(0, 0, 0, 1);
        put_voxel(63, 63, 63, 1);
        put_voxel(63, 63, 63, 0);
        put_voxel(5, 3, 7, 1);
        put_voxel(9, 3, 7, 1);
        put_voxel(63, 0, 63, 1);
        cast_ray({6'd5, 16'h8000}, {6'd3, 16'h8000}, {6'd7, 16'h8000}, 0, 0, 0);
        cast_ray({6'd6, 16'h8000}, {6'd3, 16'h8000}, {6'd7, 16'h8000}, 0, 0, 0);
        cast_ray({6'd6, 16'h0000}, {6'd3, 16'h8000}, {6'd7, 16'h8000}, 16384, 0, 0);
        cast_ray({6'd6, 16'h0000}, {6'd3, 16'h8000}, {6'd7, 16'h8000}, -16384, 0, 0);
        cast_ray({6'd10, 16'h0000}, {6'd3, 16'h0000}, {6'd7, 16'h0000}, -32768, 0, 0);
        cast_ray({6'd12, 16'h0000}, {6'd3, 16'h8000}, {6'd7, 16'h8000}, 16'h7FFF, 0, 0);
        cast_ray({6'd1, 16'h8000}, {6'd1, 16'h8000}, {6'd1, 16'h8000}, -16384, -16384, -16384);
        cast_ray({6'd4, 16'h8000}, {6'd2, 16'h8000}, {6'd6, 16'h8000}, 16384, 16384, 16384);
        cast_ray({6'd60, 16'h0}, {6'd5, 16'h0}, {6'd60, 16'h0}, 16384, -16384, 16384);
        cast_ray('1, '1, '1, 0, 0, 0);
        cast_ray('1, '1, '1, 16384, 16384, 16384);
        cast_ray('0, '0, '0, -16384, -16384, -16384);
        cast_ray({6'd20, 16'h0}, {6'd0, 16'h0}, {6'd20, 16'h0}, 0, 16384, 0);
        cast_ray({6'd62, 16'hFFFF}, {6'd62, 16'hFFFF}, {6'd62, 16'hFFFF}, 16'h8000, 16'h8000, 16'h8000);

        // random: writes and casts focused on one corner of the world
        for (n = 0; n < 1300; n++) begin
            calm = (n >= 450 && n < 750);
            if (n == 900) begin
                // drain: let the last accepted item reach the checker, then wait it out
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            maybe_idle();
            dense = $urandom_range(99) < 70;
            if ($urandom_range(99) < 40) begin
                if (dense)
                    put_voxel($urandom_range(15), $urandom_range(15), $urandom_range(15),
                              $urandom_range(99) < 70);
                else
                    put_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63),
                              1'($urandom));
            end else begin
                cast_ray(pick_org(dense), pick_org(dense), pick_org(dense),
                         pick_dir(), pick_dir(), pick_dir());
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Ran %0d ray casts (%0d hits) among voxel writes and random stalls.",
                 casts, hits);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/vrt_pkg.sv
hdl/vrt_ram.sv
hdl/vrt_datapath.sv
hdl/vrt_ctrl.sv
hdl/voxel_ray_traversal_unit.sv
hdl/vrt_checker.sv
tb/sv/vrt_ray_checker.sv
tb/sv/tb_voxel_ray_traversal_unit.sv
